[rtl/utf8_to_legacy_7bit_transcoder_defines.svh]
// Assertion macros used by the transcoder top level.
`ifndef UTF8_TO_LEGACY_7BIT_TRANSCODER_DEFINES_SVH
`define UTF8_TO_LEGACY_7BIT_TRANSCODER_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet in reset.
`define U7T_ASSERT_SAME(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("transcoder same-cycle check failed");

// Next-cycle implication, sampled on clk, quiet in reset.
`define U7T_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("transcoder next-cycle check failed");

`endif

[rtl/u7t_pkg.sv]
// Types, constants and lookup functions of the UTF-8 to 7-bit transcoder.
package u7t_pkg;

    localparam logic [7:0] LEAD_TWO_MIN   = 8'o300;
    localparam logic [7:0] LEAD_THREE_MIN = 8'o340;
    localparam logic [7:0] LEAD_FOUR_MIN  = 8'o360;
    localparam logic [7:0] LEAD_BAD_MIN   = 8'o370;
    localparam logic [7:0] CONT_MIN       = 8'o200;
    localparam logic [7:0] LEAD_ARROWS    = 8'o342;

    // Byte held by the input stage.
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } stage_t;

    // Result of one decode step.
    typedef struct packed {
        logic       valid;
        logic [6:0] code;
        logic       mapped;
    } result_t;

    // Lookup outcome of a glyph table.
    typedef struct packed {
        logic       hit;
        logic [6:0] code;
    } glyph_t;

    // Remap the seven special ASCII codes, pass the rest.
    function automatic logic [6:0] ascii_map(input logic [6:0] a);
        logic [6:0] r;
        case (a)
            7'o033:  r = 7'o175;
            7'o010:  r = 7'o177;
            7'o136:  r = 7'o004;
            7'o137:  r = 7'o030;
            7'o175:  r = 7'o176;
            7'o176:  r = 7'o032;
            7'o177:  r = 7'o010;
            default: r = a;
        endcase
        return r;
    endfunction

    // Two-byte glyphs keyed by lead and last byte.
    function automatic glyph_t two_lookup(input logic [7:0] k1, input logic [7:0] k2);
        glyph_t g;
        g.hit = 1'b1;
        case ({k1, k2})
            {8'o302, 8'o254}: g.code = 7'o005;
            {8'o316, 8'o261}: g.code = 7'o002;
            {8'o316, 8'o262}: g.code = 7'o003;
            {8'o316, 8'o265}: g.code = 7'o006;
            {8'o316, 8'o273}: g.code = 7'o010;
            {8'o317, 8'o200}: g.code = 7'o007;
            default:
            begin
                g.hit  = 1'b0;
                g.code = 7'd0;
            end
        endcase
        return g;
    endfunction

    // Three-byte glyphs under the arrows lead, keyed by second and last byte.
    function automatic glyph_t three_lookup(input logic [7:0] k1, input logic [7:0] k2);
        glyph_t g;
        g.hit = 1'b1;
        case ({k1, k2})
            {8'o206, 8'o220}: g.code = 7'o137;
            {8'o206, 8'o221}: g.code = 7'o136;
            {8'o206, 8'o222}: g.code = 7'o031;
            {8'o206, 8'o223}: g.code = 7'o001;
            {8'o206, 8'o224}: g.code = 7'o027;
            {8'o210, 8'o200}: g.code = 7'o024;
            {8'o210, 8'o202}: g.code = 7'o017;
            {8'o210, 8'o203}: g.code = 7'o025;
            {8'o210, 8'o236}: g.code = 7'o016;
            {8'o210, 8'o247}: g.code = 7'o004;
            {8'o210, 8'o250}: g.code = 7'o037;
            {8'o210, 8'o251}: g.code = 7'o022;
            {8'o210, 8'o252}: g.code = 7'o023;
            {8'o211, 8'o240}: g.code = 7'o033;
            {8'o211, 8'o241}: g.code = 7'o036;
            {8'o211, 8'o244}: g.code = 7'o034;
            {8'o211, 8'o245}: g.code = 7'o035;
            {8'o212, 8'o202}: g.code = 7'o020;
            {8'o212, 8'o203}: g.code = 7'o021;
            {8'o223, 8'o247}: g.code = 7'o026;
            default:
            begin
                g.hit  = 1'b0;
                g.code = 7'd0;
            end
        endcase
        return g;
    endfunction

endpackage

[rtl/u7t_ifs.sv]
// Channel interfaces of the transcoder: byte input and code output.
interface u7t_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;

    modport source (output valid, output byte_in, input ready);
    modport sink   (input valid, input byte_in, output ready);
endinterface

interface u7t_code_if;
    logic       valid;
    logic       ready;
    logic [6:0] code;
    logic       mapped;

    modport source (output valid, output code, output mapped, input ready);
    modport sink   (input valid, input code, input mapped, output ready);
endinterface

[rtl/utf8_to_legacy_7bit_transcoder.sv]
// UTF-8 to 7-bit legacy code transcoder, top level.
// Takes one UTF-8 byte per beat on bytes and gives one 7-bit code per
// completed character on codes, with mapped low for unknown or malformed
// characters (code 0). A byte goes through an input register, the decoder
// (character state plus table lookup) and a result register, and one byte
// is accepted every cycle as long as codes keeps taking results. Bytes that
// complete no character leave no beat. The result register's readiness sets
// the pace: when a result waits untaken, one more byte is taken into the
// input register and then bytes stall.
`include "utf8_to_legacy_7bit_transcoder_defines.svh"

module utf8_to_legacy_7bit_transcoder
    import u7t_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    u7t_byte_if.sink    bytes,
    u7t_code_if.source  codes
);

    stage_t  stage;
    result_t res;
    logic    space;
    logic    fire;
    logic    idle;

    // Consume the staged byte whenever the result register can take its outcome.
    assign fire = stage.valid && space;

    u7t_in_stage u_in_stage
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .bytes   (bytes),
        .advance (space),
        .stage   (stage)
    );

    u7t_decoder u_decoder
    (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .data  (stage.data),
        .idle  (idle),
        .res   (res)
    );

    u7t_out_reg u_out_reg
    (
        .clk   (clk),
        .rst_n (rst_n),
        .res   (res),
        .space (space),
        .codes (codes)
    );

    // A staged ASCII byte at a character boundary yields a mapped code next cycle.
    `U7T_ASSERT_NEXT(a_ascii_result, fire && idle && !stage.data[7], codes.valid && codes.mapped)
    // A staged byte that cannot move stays staged.
    `U7T_ASSERT_NEXT(a_stage_hold, stage.valid && !space, stage.valid)
    // A continuation byte never produces a result unless it ends the character.
    `U7T_ASSERT_SAME(a_mid_silent, fire && !idle && res.valid, u_decoder.bytes_left_reg == 2'd1)

endmodule

[rtl/u7t_in_stage.sv]
// Input register: captures one byte beat and holds it until the decoder takes it.
module u7t_in_stage
    import u7t_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    u7t_byte_if.sink      bytes,
    input  logic          advance,
    output stage_t        stage
);

    logic       valid_reg;
    logic [7:0] data_reg;

    // Take a beat when empty or when the held byte leaves this cycle.
    assign bytes.ready = !valid_reg || advance;

    // Track occupancy.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (bytes.valid && bytes.ready)
        begin
            valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Hold the payload.
    always_ff @(posedge clk)
    begin
        if (bytes.valid && bytes.ready)
        begin
            data_reg <= bytes.byte_in;
        end
    end

    assign stage.valid = valid_reg;
    assign stage.data  = data_reg;

endmodule

[rtl/u7t_decoder.sv]
// Character decoder: lead/continuation tracking and glyph lookup, one byte per step.
module u7t_decoder
    import u7t_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       fire,
    input  logic [7:0] data,
    output logic       idle,
    output result_t    res
);

    logic [7:0] lead_byte_reg,     lead_byte_next;
    logic [7:0] second_byte_reg,   second_byte_next;
    logic [1:0] bytes_left_reg,    bytes_left_next;
    logic [1:0] byte_position_reg, byte_position_next;
    logic [1:0] left_dec;
    glyph_t     two_g;
    glyph_t     three_g;

    assign idle     = (bytes_left_reg == 2'd0);
    assign left_dec = bytes_left_reg - 2'd1;
    assign two_g    = two_lookup(lead_byte_reg, data);
    assign three_g  = three_lookup(second_byte_reg, data);

    // Step the character state and form the result.
    always_comb
    begin
        lead_byte_next     = lead_byte_reg;
        second_byte_next   = second_byte_reg;
        bytes_left_next    = bytes_left_reg;
        byte_position_next = byte_position_reg;
        res.valid          = 1'b0;
        res.code           = 7'd0;
        res.mapped         = 1'b0;
        if (bytes_left_reg == 2'd0)
        begin
            if (data < CONT_MIN)
            begin
                res.valid  = 1'b1;
                res.code   = ascii_map(data[6:0]);
                res.mapped = 1'b1;
            end
            else if (data < LEAD_TWO_MIN || data >= LEAD_BAD_MIN)
            begin
                res.valid = 1'b1;
            end
            else
            begin
                lead_byte_next     = data;
                second_byte_next   = 8'd0;
                byte_position_next = 2'd1;
                if (data < LEAD_THREE_MIN)
                begin
                    bytes_left_next = 2'd1;
                end
                else if (data < LEAD_FOUR_MIN)
                begin
                    bytes_left_next = 2'd2;
                end
                else
                begin
                    bytes_left_next = 2'd3;
                end
            end
        end
        else
        begin
            if (byte_position_reg == 2'd1)
            begin
                second_byte_next = data;
            end
            bytes_left_next    = left_dec;
            byte_position_next = byte_position_reg + 2'd1;
            if (left_dec == 2'd0)
            begin
                byte_position_next = 2'd0;
                res.valid          = 1'b1;
                if (lead_byte_reg >= LEAD_TWO_MIN && lead_byte_reg < LEAD_THREE_MIN)
                begin
                    res.code   = two_g.code;
                    res.mapped = two_g.hit;
                end
                else if (lead_byte_reg == LEAD_ARROWS)
                begin
                    res.code   = three_g.code;
                    res.mapped = three_g.hit;
                end
            end
        end
        if (!fire)
        begin
            res.valid = 1'b0;
        end
    end

    // Advance the state on each consumed byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lead_byte_reg     <= 8'd0;
            second_byte_reg   <= 8'd0;
            bytes_left_reg    <= 2'd0;
            byte_position_reg <= 2'd0;
        end
        else if (fire)
        begin
            lead_byte_reg     <= lead_byte_next;
            second_byte_reg   <= second_byte_next;
            bytes_left_reg    <= bytes_left_next;
            byte_position_reg <= byte_position_next;
        end
    end

endmodule

[rtl/u7t_out_reg.sv]
// Result register: holds one code beat for the downstream side.
module u7t_out_reg
    import u7t_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  result_t    res,
    output logic       space,
    u7t_code_if.source codes
);

    logic       valid_reg;
    logic [6:0] code_reg;
    logic       mapped_reg;

    // Free when empty or when the held beat is taken now.
    assign space = !valid_reg || codes.ready;

    // Track occupancy.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (space)
        begin
            valid_reg <= res.valid;
        end
    end

    // Load the payload.
    always_ff @(posedge clk)
    begin
        if (space && res.valid)
        begin
            code_reg   <= res.code;
            mapped_reg <= res.mapped;
        end
    end

    assign codes.valid  = valid_reg;
    assign codes.code   = code_reg;
    assign codes.mapped = mapped_reg;

endmodule
